// File: src/mhs_pkg.sv
// Package for the motor homing sequencer: codes, payload and state types,
// configuration reset values and the homing phase table.
// No dependencies; mhs_csr, mhs_step and the top level use it.
package mhs_pkg;

   // Width of the elapsed tick counter unless the top level overrides it.
   localparam int TIMER_BITS_DEFAULT = 16;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_UP_TIMEOUT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_DOWN_TIMEOUT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOIST_DOWN_TIMEOUT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILT_TIMEOUT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_PULSE      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRAKE_HOLD         = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAISE_DUTY         = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_DUTY         = 3'd7;

   // Configuration reset values.
   localparam logic [15:0] RST_HEAD_UP_TIMEOUT    = 16'd5000;
   localparam logic [15:0] RST_HEAD_DOWN_TIMEOUT  = 16'd5000;
   localparam logic [15:0] RST_HOIST_DOWN_TIMEOUT = 16'd5000;
   localparam logic [15:0] RST_TILT_TIMEOUT       = 16'd3000;
   localparam logic [15:0] RST_RELEASE_PULSE      = 16'd100;
   localparam logic [15:0] RST_BRAKE_HOLD         = 16'd100;
   localparam logic [7:0]  RST_RAISE_DUTY         = 8'd210;
   localparam logic [7:0]  RST_LOWER_DUTY         = 8'd75;

   // Command opcodes.
   localparam logic [2:0] OP_NONE        = 3'd0;
   localparam logic [2:0] OP_HOMING      = 3'd1;
   localparam logic [2:0] OP_RAISE_HEAD  = 3'd2;
   localparam logic [2:0] OP_LOWER_HEAD  = 3'd3;
   localparam logic [2:0] OP_LOWER_HOIST = 3'd4;
   localparam logic [2:0] OP_TILT_UP     = 3'd5;
   localparam logic [2:0] OP_ROD_DOWN    = 3'd6;

   // Motion codes, as reported in active_motion.
   localparam logic [2:0] MOT_NONE        = 3'd0;
   localparam logic [2:0] MOT_RAISE_HEAD  = 3'd1;
   localparam logic [2:0] MOT_LOWER_HEAD  = 3'd2;
   localparam logic [2:0] MOT_LOWER_HOIST = 3'd3;
   localparam logic [2:0] MOT_TILT_UP     = 3'd4;
   localparam logic [2:0] MOT_ROD_DOWN    = 3'd5;

   // Run status codes.
   localparam logic [1:0] STAT_IDLE     = 2'd0;
   localparam logic [1:0] STAT_WORKING  = 2'd1;
   localparam logic [1:0] STAT_COMPLETE = 2'd2;
   localparam logic [1:0] STAT_ERROR    = 2'd3;

   // Last phase of the homing sequence.
   localparam logic [2:0] SEQ_LAST_PHASE = 3'd4;

   // Per-motion step.
   typedef enum logic [6:0] {
      STEP_IDLE  = 7'b0000001,
      STEP_WORK  = 7'b0000010,
      STEP_DONE  = 7'b0000100,
      STEP_OK    = 7'b0001000,
      STEP_ERR   = 7'b0010000,
      STEP_PULSE = 7'b0100000,
      STEP_HOLD  = 7'b1000000
   } step_type;

   typedef struct packed {
      logic [15:0] head_up_timeout;
      logic [15:0] head_down_timeout;
      logic [15:0] hoist_down_timeout;
      logic [15:0] tilt_timeout;
      logic [15:0] release_pulse_ticks;
      logic [15:0] brake_hold_ticks;
      logic [7:0]  raise_duty;
      logic [7:0]  lower_duty;
   } cfg_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       head_up;
      logic       head_down;
      logic       tilt_up;
      logic       rod_down;
      logic       hoist_down;
   } req_type;

   typedef struct packed {
      logic [7:0] hoist_duty;
      logic       hoist_enable;
      logic       hoist_reverse;
      logic       tilt_enable;
      logic       tilt_upward;
      logic       brake_on;
      logic       solenoid_on;
   } drive_type;

   typedef struct packed {
      drive_type  drive;
      logic [1:0] run_status;
      logic [2:0] active_motion;
   } rsp_type;

   typedef struct packed {
      logic [2:0] motion_sel;
      step_type   motion_step;
      logic [2:0] sequence_phase;
      logic       in_sequence;
      drive_type  drive;
   } state_type;

   // Motion run in each phase of the homing sequence.
   function automatic logic [2:0] phase_motion(input logic [2:0] phase);
      logic [2:0] mot;
      unique case (phase)
         3'd0:    mot = MOT_ROD_DOWN;
         3'd1:    mot = MOT_RAISE_HEAD;
         3'd2:    mot = MOT_TILT_UP;
         3'd3:    mot = MOT_ROD_DOWN;
         3'd4:    mot = MOT_LOWER_HOIST;
         default: mot = MOT_NONE;
      endcase
      return mot;
   endfunction

endpackage

// File: src/mhs_if.sv
// Valid/ready channel interfaces for tick requests and drive responses.
// Depends on nothing; the top level of the sequencer uses both.
interface mhs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic       head_up;
   logic       head_down;
   logic       tilt_up;
   logic       rod_down;
   logic       hoist_down;

   modport source (output valid, opcode, head_up, head_down, tilt_up, rod_down,
                   hoist_down, input ready);
   modport sink   (input valid, opcode, head_up, head_down, tilt_up, rod_down,
                   hoist_down, output ready);
endinterface

interface mhs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] hoist_duty;
   logic       hoist_enable;
   logic       hoist_reverse;
   logic       tilt_enable;
   logic       tilt_upward;
   logic       brake_on;
   logic       solenoid_on;
   logic [1:0] run_status;
   logic [2:0] active_motion;

   modport source (output valid, hoist_duty, hoist_enable, hoist_reverse, tilt_enable,
                   tilt_upward, brake_on, solenoid_on, run_status, active_motion,
                   input ready);
   modport sink   (input valid, hoist_duty, hoist_enable, hoist_reverse, tilt_enable,
                   tilt_upward, brake_on, solenoid_on, run_status, active_motion,
                   output ready);
endinterface

// File: src/mhs_csr.sv
// Configuration register bank of the motor homing sequencer.
// Depends on mhs_pkg for register indexes, reset values and cfg_type.
module mhs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [mhs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mhs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output mhs_pkg::cfg_type                  cfg
);

   mhs_pkg::cfg_type cfg_ff;
   mhs_pkg::cfg_type cfg_in;

   // Decode the register index and update the addressed field.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mhs_pkg::CSR_HEAD_UP_TIMEOUT:    cfg_in.head_up_timeout     = csr_wdata;
            mhs_pkg::CSR_HEAD_DOWN_TIMEOUT:  cfg_in.head_down_timeout   = csr_wdata;
            mhs_pkg::CSR_HOIST_DOWN_TIMEOUT: cfg_in.hoist_down_timeout  = csr_wdata;
            mhs_pkg::CSR_TILT_TIMEOUT:       cfg_in.tilt_timeout        = csr_wdata;
            mhs_pkg::CSR_RELEASE_PULSE:      cfg_in.release_pulse_ticks = csr_wdata;
            mhs_pkg::CSR_BRAKE_HOLD:         cfg_in.brake_hold_ticks    = csr_wdata;
            mhs_pkg::CSR_RAISE_DUTY:         cfg_in.raise_duty          = csr_wdata[7:0];
            mhs_pkg::CSR_LOWER_DUTY:         cfg_in.lower_duty          = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Registers come out of reset with their documented values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_up_timeout     <= mhs_pkg::RST_HEAD_UP_TIMEOUT;
         cfg_ff.head_down_timeout   <= mhs_pkg::RST_HEAD_DOWN_TIMEOUT;
         cfg_ff.hoist_down_timeout  <= mhs_pkg::RST_HOIST_DOWN_TIMEOUT;
         cfg_ff.tilt_timeout        <= mhs_pkg::RST_TILT_TIMEOUT;
         cfg_ff.release_pulse_ticks <= mhs_pkg::RST_RELEASE_PULSE;
         cfg_ff.brake_hold_ticks    <= mhs_pkg::RST_BRAKE_HOLD;
         cfg_ff.raise_duty          <= mhs_pkg::RST_RAISE_DUTY;
         cfg_ff.lower_duty          <= mhs_pkg::RST_LOWER_DUTY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/mhs_step.sv
// Combinational tick logic: next motion state, elapsed count and drive result.
// Depends on mhs_pkg for codes, the phase table and the state types.
module mhs_step #(
   parameter int TIMER_BITS = mhs_pkg::TIMER_BITS_DEFAULT
) (
   input  mhs_pkg::state_type       state_cur,
   input  logic [TIMER_BITS-1:0]    elapsed_cur,
   input  mhs_pkg::req_type         req,
   input  mhs_pkg::cfg_type         cfg,
   output mhs_pkg::state_type       state_nxt,
   output logic [TIMER_BITS-1:0]    elapsed_nxt,
   output mhs_pkg::rsp_type         rsp
);

   // Compares run at the wider of the counter and the 16-bit registers.
   localparam int CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   mhs_pkg::state_type    st;
   logic [TIMER_BITS-1:0] el;
   logic                  hoist_target;
   logic                  hoist_raise;
   logic                  hoist_skip;
   logic [15:0]           hoist_limit;
   logic                  tilt_target;
   logic                  tilt_dir_up;
   logic                  tilt_need_head;
   logic [1:0]            status;

   // Motion selected after the command of this tick is applied.
   function automatic logic [2:0] st_sel_pre();
      logic [2:0] sel;
      if (req.opcode == mhs_pkg::OP_HOMING) begin
         sel = mhs_pkg::phase_motion(3'd0);
      end else if (req.opcode >= mhs_pkg::OP_RAISE_HEAD &&
                   req.opcode <= mhs_pkg::OP_ROD_DOWN) begin
         sel = req.opcode - 3'd1;
      end else begin
         sel = state_cur.motion_sel;
      end
      return sel;
   endfunction

   // Operand selection for the shared hoist and tilt step logic.
   always_comb begin
      hoist_raise    = (st_sel_pre() == mhs_pkg::MOT_RAISE_HEAD);
      hoist_target   = hoist_raise ? req.head_up : req.hoist_down;
      hoist_skip     = hoist_raise ? (req.head_up | req.tilt_up) : req.hoist_down;
      hoist_limit    = hoist_raise ? cfg.head_up_timeout : cfg.hoist_down_timeout;
      tilt_dir_up    = (st_sel_pre() == mhs_pkg::MOT_TILT_UP);
      tilt_target    = tilt_dir_up ? req.tilt_up : req.rod_down;
      tilt_need_head = tilt_dir_up;
   end

   always_comb begin
      st = state_cur;

      // The counter advances at the start of every tick and saturates.
      el = (elapsed_cur == '1) ? elapsed_cur : elapsed_cur + 1'b1;

      // A command restarts the chosen motion.
      if (req.opcode == mhs_pkg::OP_HOMING) begin
         st.in_sequence    = 1'b1;
         st.sequence_phase = 3'd0;
         st.motion_sel     = mhs_pkg::phase_motion(3'd0);
         st.motion_step    = mhs_pkg::STEP_IDLE;
      end else if (req.opcode >= mhs_pkg::OP_RAISE_HEAD &&
                   req.opcode <= mhs_pkg::OP_ROD_DOWN) begin
         st.in_sequence    = 1'b0;
         st.sequence_phase = 3'd0;
         st.motion_sel     = req.opcode - 3'd1;
         st.motion_step    = mhs_pkg::STEP_IDLE;
      end

      // Poll the current motion.
      unique case (st.motion_sel) inside
         mhs_pkg::MOT_RAISE_HEAD, mhs_pkg::MOT_LOWER_HOIST: begin
            unique case (st.motion_step)
               mhs_pkg::STEP_IDLE: begin
                  if (hoist_skip) begin
                     st.motion_step = mhs_pkg::STEP_DONE;
                  end else begin
                     el = '0;
                     st.drive.hoist_duty    = hoist_raise ? cfg.raise_duty : cfg.lower_duty;
                     st.drive.hoist_reverse = ~hoist_raise;
                     st.drive.hoist_enable  = 1'b1;
                     st.motion_step         = mhs_pkg::STEP_WORK;
                  end
               end
               mhs_pkg::STEP_WORK: begin
                  if (hoist_target) begin
                     st.motion_step = mhs_pkg::STEP_DONE;
                  end else if (CmpW'(el) > CmpW'(hoist_limit)) begin
                     st.motion_step        = mhs_pkg::STEP_ERR;
                     st.drive.hoist_duty   = '0;
                     st.drive.hoist_enable = 1'b0;
                     st.drive.tilt_enable  = 1'b0;
                     st.drive.brake_on     = 1'b0;
                  end
               end
               mhs_pkg::STEP_DONE: begin
                  st.drive.hoist_enable = 1'b0;
                  st.drive.hoist_duty   = '0;
                  st.motion_step        = mhs_pkg::STEP_OK;
               end
               default: ;
            endcase
         end
         mhs_pkg::MOT_LOWER_HEAD: begin
            unique case (st.motion_step)
               mhs_pkg::STEP_IDLE: begin
                  if (req.head_down) begin
                     st.motion_step = mhs_pkg::STEP_DONE;
                  end else begin
                     el = '0;
                     // A zero-length pulse ends on the tick that starts it.
                     if (cfg.release_pulse_ticks == '0) begin
                        st.drive.solenoid_on = 1'b0;
                        st.motion_step       = mhs_pkg::STEP_WORK;
                     end else begin
                        st.drive.solenoid_on = 1'b1;
                        st.motion_step       = mhs_pkg::STEP_PULSE;
                     end
                  end
               end
               mhs_pkg::STEP_PULSE: begin
                  if (CmpW'(el) >= CmpW'(cfg.release_pulse_ticks)) begin
                     st.drive.solenoid_on = 1'b0;
                     st.motion_step       = mhs_pkg::STEP_WORK;
                  end
               end
               mhs_pkg::STEP_WORK: begin
                  if (req.head_down) begin
                     st.motion_step = mhs_pkg::STEP_DONE;
                  end else if (CmpW'(el) > CmpW'(cfg.head_down_timeout)) begin
                     st.motion_step        = mhs_pkg::STEP_ERR;
                     st.drive.hoist_duty   = '0;
                     st.drive.hoist_enable = 1'b0;
                     st.drive.tilt_enable  = 1'b0;
                     st.drive.brake_on     = 1'b0;
                  end
               end
               mhs_pkg::STEP_DONE: begin
                  st.motion_step = mhs_pkg::STEP_OK;
               end
               default: ;
            endcase
         end
         mhs_pkg::MOT_TILT_UP, mhs_pkg::MOT_ROD_DOWN: begin
            unique case (st.motion_step)
               mhs_pkg::STEP_IDLE: begin
                  if (tilt_target) begin
                     st.motion_step = mhs_pkg::STEP_DONE;
                  end else if (tilt_need_head && !req.head_up) begin
                     st.motion_step = mhs_pkg::STEP_ERR;
                  end else begin
                     el = '0;
                     st.drive.tilt_upward = tilt_dir_up;
                     st.drive.tilt_enable = 1'b1;
                     st.motion_step       = mhs_pkg::STEP_WORK;
                  end
               end
               mhs_pkg::STEP_WORK: begin
                  if (tilt_target) begin
                     st.motion_step = mhs_pkg::STEP_DONE;
                  end else if (CmpW'(el) > CmpW'(cfg.tilt_timeout)) begin
                     st.motion_step        = mhs_pkg::STEP_ERR;
                     st.drive.hoist_duty   = '0;
                     st.drive.hoist_enable = 1'b0;
                     st.drive.tilt_enable  = 1'b0;
                     st.drive.brake_on     = 1'b0;
                  end
               end
               mhs_pkg::STEP_DONE: begin
                  // The hold timer restarts; the brake goes on unless a zero hold ends at once.
                  el = '0;
                  if (cfg.brake_hold_ticks == '0) begin
                     st.drive.tilt_enable = 1'b0;
                     st.drive.brake_on    = 1'b0;
                     st.motion_step       = mhs_pkg::STEP_OK;
                  end else begin
                     st.drive.brake_on = 1'b1;
                     st.motion_step    = mhs_pkg::STEP_HOLD;
                  end
               end
               mhs_pkg::STEP_HOLD: begin
                  if (CmpW'(el) >= CmpW'(cfg.brake_hold_ticks)) begin
                     st.drive.tilt_enable = 1'b0;
                     st.drive.brake_on    = 1'b0;
                     st.motion_step       = mhs_pkg::STEP_OK;
                  end
               end
               default: ;
            endcase
         end
         default: begin
            st.motion_sel  = mhs_pkg::MOT_NONE;
            st.motion_step = mhs_pkg::STEP_IDLE;
         end
      endcase

      // Homing sequence hand-over and stop.
      if (st.in_sequence) begin
         if (st.motion_step == mhs_pkg::STEP_OK &&
             st.sequence_phase < mhs_pkg::SEQ_LAST_PHASE) begin
            st.sequence_phase = st.sequence_phase + 3'd1;
            st.motion_sel     = mhs_pkg::phase_motion(st.sequence_phase);
            st.motion_step    = mhs_pkg::STEP_IDLE;
         end else if (st.motion_step == mhs_pkg::STEP_OK ||
                      st.motion_step == mhs_pkg::STEP_ERR) begin
            st.in_sequence = 1'b0;
         end
      end
   end

   // Status as seen after this tick.
   always_comb begin
      unique case (st.motion_step)
         mhs_pkg::STEP_IDLE: status = st.in_sequence ? mhs_pkg::STAT_WORKING
                                                     : mhs_pkg::STAT_IDLE;
         mhs_pkg::STEP_OK:   status = mhs_pkg::STAT_COMPLETE;
         mhs_pkg::STEP_ERR:  status = mhs_pkg::STAT_ERROR;
         default:            status = mhs_pkg::STAT_WORKING;
      endcase
   end

   assign state_nxt         = st;
   assign elapsed_nxt       = el;
   assign rsp.drive         = st.drive;
   assign rsp.run_status    = status;
   assign rsp.active_motion = st.motion_sel;

endmodule

// File: src/motor_homing_sequencer.sv
// Top level of the motor homing sequencer: input register, motion state,
// result register and configuration bank. Depends on mhs_pkg, mhs_if.sv,
// mhs_csr and mhs_step.
//
// Each accepted request is one timer tick and yields exactly one response
// carrying the drive levels, run status and active motion after that tick.
// The block takes one tick per clock cycle while the output side is not stalled:
// a request is captured in an input register, evaluated by a single pass of
// compare-and-update logic against the motion state, and the response is held in
// an output register. Motion state only advances when a response is written,
// so a stalled output holds both registers full and drops ready. The elapsed
// tick counter is TIMER_BITS wide and saturates at its maximum.
// Configuration registers should be written only when no tick is in
// flight; they reset to their documented values and need no start-up pass.
module motor_homing_sequencer #(
   parameter int TIMER_BITS = mhs_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   mhs_req_if.sink                           req_chan,
   mhs_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [mhs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mhs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   mhs_pkg::cfg_type      cfg;
   mhs_pkg::req_type      req_pay;
   mhs_pkg::req_type      in_ff;
   logic                  in_vld_ff;
   mhs_pkg::state_type    state_ff;
   mhs_pkg::state_type    state_in;
   logic [TIMER_BITS-1:0] elapsed_ff;
   logic [TIMER_BITS-1:0] elapsed_in;
   mhs_pkg::rsp_type      rsp_in;
   mhs_pkg::rsp_type      rsp_ff;
   logic                  rsp_vld_ff;
   logic                  advance;
   logic                  req_take;

   mhs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mhs_step #(
      .TIMER_BITS (TIMER_BITS)
   ) u_step (
      .state_cur   (state_ff),
      .elapsed_cur (elapsed_ff),
      .req         (in_ff),
      .cfg         (cfg),
      .state_nxt   (state_in),
      .elapsed_nxt (elapsed_in),
      .rsp         (rsp_in)
   );

   // Request payload gathered from the channel.
   assign req_pay.opcode     = req_chan.opcode;
   assign req_pay.head_up    = req_chan.head_up;
   assign req_pay.head_down  = req_chan.head_down;
   assign req_pay.tilt_up    = req_chan.tilt_up;
   assign req_pay.rod_down   = req_chan.rod_down;
   assign req_pay.hoist_down = req_chan.hoist_down;

   // The held tick is evaluated when the output register is free or draining.
   assign advance        = in_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_pay;
      end
   end

   // Motion state and elapsed counter move once per evaluated tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.motion_sel     <= mhs_pkg::MOT_NONE;
         state_ff.motion_step    <= mhs_pkg::STEP_IDLE;
         state_ff.sequence_phase <= '0;
         state_ff.in_sequence    <= 1'b0;
         state_ff.drive          <= '0;
         elapsed_ff              <= '0;
      end else if (advance) begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.hoist_duty    = rsp_ff.drive.hoist_duty;
   assign rsp_chan.hoist_enable  = rsp_ff.drive.hoist_enable;
   assign rsp_chan.hoist_reverse = rsp_ff.drive.hoist_reverse;
   assign rsp_chan.tilt_enable   = rsp_ff.drive.tilt_enable;
   assign rsp_chan.tilt_upward   = rsp_ff.drive.tilt_upward;
   assign rsp_chan.brake_on      = rsp_ff.drive.brake_on;
   assign rsp_chan.solenoid_on   = rsp_ff.drive.solenoid_on;
   assign rsp_chan.run_status    = rsp_ff.run_status;
   assign rsp_chan.active_motion = rsp_ff.active_motion;

endmodule
